FILE: rtl/dvc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvc_pkg: shared types and constants of the dotted version comparator
// Character codes, token format between front and back, and verdict codes.
// ----------------------------------------------------------------------------
package dvc_pkg;

	// character codes
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_DOT  = 8'h2E;

	// decimal radix and width of one digit
	localparam int RADIX   = 10;
	localparam int DIGIT_W = 4;

	// depths of the token queue and the result queue
	localparam int TOK_DEPTH = 2;
	localparam int OUT_DEPTH = 2;

	// verdict codes
	localparam int VERDICT_W = 2;
	typedef logic [VERDICT_W-1:0] verdict_t;
	localparam verdict_t V_INVALID   = 2'd0;
	localparam verdict_t V_UPDATE    = 2'd1;
	localparam verdict_t V_NO_UPDATE = 2'd2;

	// class of one classified character
	typedef enum logic [1:0] {
		TK_DIGIT,
		TK_DOT,
		TK_OTHER,
		TK_END
	} tok_kind_t;

	// token handed from the front to the back
	typedef struct packed {
		logic               sel;
		tok_kind_t          kind;
		logic [DIGIT_W-1:0] digit;
	} token_t;

endpackage

FILE: rtl/dvc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvc_queue: small synchronous queue
// Register-based first-in first-out buffer with full and empty flags.
// ----------------------------------------------------------------------------
module dvc_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	// flags and handshake qualification
	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

FILE: rtl/dvc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvc_front: request classifier
// Turns one accepted character request into a token for the parser.
// ----------------------------------------------------------------------------
module dvc_front import dvc_pkg::*; (
	input  logic       push,
	input  logic       full,
	input  logic       which_string,
	input  logic       is_end,
	input  logic [7:0] char_code,
	output logic       tok_push,
	output token_t     tok
);

	logic       is_digit;
	logic [7:0] digit_full;

	assign tok_push   = push && !full;
	assign is_digit   = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
	assign digit_full = char_code - CH_ZERO;

	// classify the character
	always_comb begin
		tok.sel   = which_string;
		tok.digit = digit_full[DIGIT_W-1:0];
		if (is_end) begin
			tok.kind = TK_END;
		end else if (is_digit) begin
			tok.kind = TK_DIGIT;
		end else if (char_code == CH_DOT) begin
			tok.kind = TK_DOT;
		end else begin
			tok.kind = TK_OTHER;
		end
	end

endmodule

FILE: rtl/dvc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvc_back: version parser and comparator
// Builds the parts of both strings from tokens and gives the verdict on the
// end of a remote string.
// ----------------------------------------------------------------------------
module dvc_back import dvc_pkg::*; #(
	parameter int MAX_PARTS  = 4,
	parameter int PART_WIDTH = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     tok_valid,
	input  token_t   tok,
	output logic     tok_pop,
	input  logic     out_full,
	output logic     out_push,
	output verdict_t out_verdict
);

	localparam int CW = $clog2(MAX_PARTS + 1);
	localparam int IW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
	localparam int AW = PART_WIDTH + DIGIT_W;

	typedef enum logic [1:0] {
		PH_START,
		PH_DIGITS,
		PH_DOT,
		PH_ERROR
	} phase_t;

	typedef logic [PART_WIDTH-1:0] part_t;

	phase_t         phase_q [2];
	phase_t         phase_d [2];
	logic [CW-1:0]  count_q [2];
	logic [CW-1:0]  count_d [2];
	logic           ready_q;
	logic           ready_d;
	part_t          cur_q [MAX_PARTS];
	part_t          cur_d [MAX_PARTS];
	part_t          rem_q [MAX_PARTS];
	part_t          rem_d [MAX_PARTS];
	part_t          sel_parts [MAX_PARTS];
	part_t          parts_w [MAX_PARTS];
	phase_t         ph;
	logic [CW-1:0]  k;
	logic [IW-1:0]  k_idx;
	part_t          cur_v;
	logic [AW-1:0]  acc;
	logic           ovf;
	logic           remote_end;
	logic           gt;

	// selected string state
	assign ph         = phase_q[tok.sel];
	assign k          = count_q[tok.sel];
	assign k_idx      = k[IW-1:0];
	assign remote_end = tok.sel && (tok.kind == TK_END);

	always_comb begin
		for (int i = 0; i < MAX_PARTS; i++) begin
			sel_parts[i] = tok.sel ? rem_q[i] : cur_q[i];
		end
	end

	// part times ten plus digit, as shift-add, with overflow detect
	assign cur_v = sel_parts[k_idx];
	assign acc   = (AW'(cur_v) << 3) + (AW'(cur_v) << 1) + AW'(tok.digit);
	assign ovf   = |acc[AW-1:PART_WIDTH];

	// lexicographic compare, first differing part decides
	always_comb begin
		gt = 1'b0;
		for (int i = MAX_PARTS - 1; i >= 0; i--) begin
			if (rem_q[i] != cur_q[i]) begin
				gt = (rem_q[i] > cur_q[i]);
			end
		end
	end

	always_comb begin
		if (!ready_q || phase_q[1] != PH_DIGITS) begin
			out_verdict = V_INVALID;
		end else if (gt) begin
			out_verdict = V_UPDATE;
		end else begin
			out_verdict = V_NO_UPDATE;
		end
	end

	// token processing
	always_comb begin
		phase_d  = phase_q;
		count_d  = count_q;
		ready_d  = ready_q;
		cur_d    = cur_q;
		rem_d    = rem_q;
		parts_w  = sel_parts;
		tok_pop  = 1'b0;
		out_push = 1'b0;
		if (tok_valid && !(remote_end && out_full)) begin
			tok_pop = 1'b1;
			if (tok.kind != TK_END) begin
				// first character of a string starts from all-zero parts
				if (ph == PH_START) begin
					for (int i = 0; i < MAX_PARTS; i++) begin
						parts_w[i] = '0;
					end
					if (!tok.sel) begin
						ready_d = 1'b0;
					end
				end
				priority if (ph == PH_ERROR) begin
					phase_d[tok.sel] = PH_ERROR;
				end else if (tok.kind == TK_DIGIT) begin
					if (ph == PH_DIGITS) begin
						if (ovf) begin
							phase_d[tok.sel] = PH_ERROR;
						end else begin
							parts_w[k_idx] = acc[PART_WIDTH-1:0];
						end
					end else if (k >= CW'(MAX_PARTS)) begin
						phase_d[tok.sel] = PH_ERROR;
					end else begin
						parts_w[k_idx]   = PART_WIDTH'(tok.digit);
						phase_d[tok.sel] = PH_DIGITS;
					end
				end else if (tok.kind == TK_DOT && ph == PH_DIGITS) begin
					count_d[tok.sel] = k + CW'(1);
					phase_d[tok.sel] = PH_DOT;
				end else begin
					phase_d[tok.sel] = PH_ERROR;
				end
				if (tok.sel) begin
					rem_d = parts_w;
				end else begin
					cur_d = parts_w;
				end
			end else if (!tok.sel) begin
				// current string ends: keep parts, note whether well-formed
				ready_d    = (ph == PH_DIGITS);
				count_d[0] = '0;
				phase_d[0] = PH_START;
			end else begin
				// remote string ends: give the verdict
				out_push   = 1'b1;
				count_d[1] = '0;
				phase_d[1] = PH_START;
			end
		end
	end

	// part storage, only read after a string has started
	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		rem_q <= rem_d;
	end

	// parser control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q[0] <= PH_START;
			phase_q[1] <= PH_START;
			count_q[0] <= '0;
			count_q[1] <= '0;
			ready_q    <= 1'b0;
		end else begin
			phase_q <= phase_d;
			count_q <= count_d;
			ready_q <= ready_d;
		end
	end

endmodule

FILE: rtl/dotted_version_compare_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dotted_version_compare_top: dotted decimal version comparator
// Parses a current and a remote version string one character per request
// and reports whether the remote version is newer.
//
//   channel   direction  handshake          payload
//   input     in         push / full        which_string, is_end, char_code
//   result    out        empty / pop        verdict
//
// One character request is taken every cycle while full is low; the parser
// handles one token per cycle unless a remote end request waits on a full
// result queue, so the sustained rate is one request per cycle while the
// result side keeps up. A verdict reaches the result side through the token
// queue, then the parser into the result queue. Reset is asynchronous and
// needs no clearing pass; the block takes requests as soon as reset is released.
// A two-entry token queue and a two-entry result queue let each side stall
// on its own; full rises only when the result queue backs up.
// ----------------------------------------------------------------------------
module dotted_version_compare_top import dvc_pkg::*; #(
	parameter int MAX_PARTS  = 4,
	parameter int PART_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       which_string,
	input  logic       is_end,
	input  logic [7:0] char_code,
	output logic       empty,
	input  logic       pop,
	output verdict_t   verdict
);

	localparam int TOK_W = $bits(token_t);

	logic       tok_push;
	token_t     tok_in;
	logic [TOK_W-1:0] tok_rdata;
	token_t     tok_out;
	logic       tok_empty;
	logic       tok_pop;
	logic       out_full;
	logic       out_push;
	verdict_t   out_verdict;

	// classify incoming requests
	dvc_front u_front (
		.push         (push),
		.full         (full),
		.which_string (which_string),
		.is_end       (is_end),
		.char_code    (char_code),
		.tok_push     (tok_push),
		.tok          (tok_in)
	);

	// token queue between front and back
	dvc_queue #(
		.WIDTH (TOK_W),
		.DEPTH (TOK_DEPTH)
	) u_tok_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (tok_push),
		.wdata  (tok_in),
		.full   (full),
		.pop    (tok_pop),
		.rdata  (tok_rdata),
		.empty  (tok_empty)
	);

	assign tok_out = token_t'(tok_rdata);

	// parse and compare
	dvc_back #(
		.MAX_PARTS  (MAX_PARTS),
		.PART_WIDTH (PART_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.tok_valid   (!tok_empty),
		.tok         (tok_out),
		.tok_pop     (tok_pop),
		.out_full    (out_full),
		.out_push    (out_push),
		.out_verdict (out_verdict)
	);

	// result queue
	dvc_queue #(
		.WIDTH (VERDICT_W),
		.DEPTH (OUT_DEPTH)
	) u_out_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (out_verdict),
		.full   (out_full),
		.pop    (pop),
		.rdata  (verdict),
		.empty  (empty)
	);

endmodule

FILE: sim/dvc_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvc_tb_pkg: codes shared by the version comparator testbench
// String select codes used both for driving requests and for prediction.
// ----------------------------------------------------------------------------
package dvc_tb_pkg;

	// which_string codes
	localparam logic STR_CURRENT = 1'b0;
	localparam logic STR_REMOTE  = 1'b1;

endpackage

FILE: sim/dvc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvc_checker: verdict predictor and scoreboard for the version comparator
// Watches both queue channels, parses every accepted character request into
// its own copy of the current and remote version parts, queues the verdict
// due on each remote end request and compares every popped verdict with it.
// ----------------------------------------------------------------------------
module dvc_checker import dvc_pkg::*; import dvc_tb_pkg::*; #(
	parameter int MAX_PARTS  = 4,
	parameter int PART_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       full,
	input  logic       which_string,
	input  logic       is_end,
	input  logic [7:0] char_code,
	input  logic       empty,
	input  logic       pop,
	input  verdict_t   verdict,
	output int         fail_count,
	output int         owed
);

	typedef enum logic [1:0] {
		PH_START,
		PH_DIGITS,
		PH_DOT,
		PH_ERROR
	} phase_t;

	localparam logic [63:0] PART_MAX =
		(PART_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << PART_WIDTH) - 64'd1);

	// parser state per string, index 0 current and 1 remote
	logic [63:0] parts    [2][MAX_PARTS];
	phase_t      phase    [2];
	int          part_idx [2];
	logic        current_ok;

	verdict_t    verdicts_due[$];
	int          fails = 0;
	int          due_count = 0;

	assign fail_count = fails;
	assign owed       = due_count;

	// restart one string parser with zero-filled parts
	task automatic clear_string(input logic s);
		int i;
		for (i = 0; i < MAX_PARTS; i++) begin
			parts[s][i] = '0;
		end
		part_idx[s] = 0;
		phase[s]    = PH_START;
	endtask

	always @(posedge clk or negedge arst_n) begin : predict
		verdict_t    want;
		logic [63:0] digit;
		logic        settled;
		int          i;
		if (!arst_n) begin
			clear_string(STR_CURRENT);
			clear_string(STR_REMOTE);
			current_ok = 1'b0;
			verdicts_due.delete();
			due_count = 0;
		end else begin
			// popped verdict against the oldest one due
			if (pop && !empty) begin
				if (due_count == 0) begin
					fails++;
					$display("%0t: verdict %0d popped with none due", $time, verdict);
				end else begin
					want = verdicts_due.pop_front();
					due_count--;
					if (verdict !== want) begin
						fails++;
						$display("%0t: verdict mismatch, expected %0d, actual %0d",
							$time, want, verdict);
					end
				end
			end

			// character request
			if (push && !full && !is_end) begin
				if (phase[which_string] == PH_START) begin
					clear_string(which_string);
					if (which_string == STR_CURRENT) begin
						current_ok = 1'b0;
					end
				end
				digit = 64'(char_code - CH_ZERO);
				if (phase[which_string] == PH_ERROR) begin
					// bytes after an error wait for the end request
				end else if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
					if (part_idx[which_string] >= MAX_PARTS) begin
						phase[which_string] = PH_ERROR;
					end else if (phase[which_string] == PH_DIGITS) begin
						// overflow marks the string malformed instead of wrapping
						if (parts[which_string][part_idx[which_string]] >
							(PART_MAX - digit) / 64'd10) begin
							phase[which_string] = PH_ERROR;
						end else begin
							parts[which_string][part_idx[which_string]] =
								parts[which_string][part_idx[which_string]] * 64'd10 + digit;
						end
					end else begin
						parts[which_string][part_idx[which_string]] = digit;
						phase[which_string] = PH_DIGITS;
					end
				end else if (char_code == CH_DOT && phase[which_string] == PH_DIGITS) begin
					part_idx[which_string]++;
					phase[which_string] = PH_DOT;
				end else begin
					phase[which_string] = PH_ERROR;
				end
			end

			// end of the current string, no verdict
			if (push && !full && is_end && which_string == STR_CURRENT) begin
				current_ok = (phase[STR_CURRENT] == PH_DIGITS);
				part_idx[STR_CURRENT] = 0;
				phase[STR_CURRENT]    = PH_START;
			end

			// end of the remote string, one verdict
			if (push && !full && is_end && which_string == STR_REMOTE) begin
				want    = V_NO_UPDATE;
				settled = 1'b0;
				if (!current_ok || phase[STR_REMOTE] != PH_DIGITS) begin
					want = V_INVALID;
				end else begin
					for (i = 0; i < MAX_PARTS; i++) begin
						if (!settled) begin
							if (parts[STR_REMOTE][i] > parts[STR_CURRENT][i]) begin
								want    = V_UPDATE;
								settled = 1'b1;
							end else if (parts[STR_REMOTE][i] < parts[STR_CURRENT][i]) begin
								settled = 1'b1;
							end
						end
					end
				end
				verdicts_due.push_back(want);
				due_count++;
				clear_string(STR_REMOTE);
			end
		end
	end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top of the dotted version comparator simulation
// Drives character requests for current and remote version strings, first a
// few hand-picked cases, then random well-formed and broken versions that sit
// close to the current one, with random gaps on both queue sides and one long
// result stall. The checker module predicts and compares every verdict.
// ----------------------------------------------------------------------------
module testbench;
	import dvc_pkg::*;
	import dvc_tb_pkg::*;

	localparam int PARTS          = 4;
	localparam int ITEM_TARGET    = 540;
	localparam int PRESSURE_AT    = 300;
	localparam int HOLD_CYCLES    = 150;
	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 1000;

	typedef logic [7:0] char_q_t[$];
	typedef longint unsigned part_q_t[$];

	// ways to break a well-formed string
	typedef enum int {
		SP_LEAD_DOT,
		SP_TRAIL_DOT,
		SP_STRAY_BYTE,
		SP_EXTRA_DOT,
		SP_EMPTY
	} spoil_t;

	// ways to derive a remote version from the current one
	typedef enum int {
		TW_SAME,
		TW_BUMP,
		TW_DROP,
		TW_TRIM,
		TW_GROW,
		TW_FRESH
	} tweak_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic       which_string = STR_CURRENT;
	logic       is_end = 1'b0;
	logic [7:0] char_code = 8'h00;
	logic       empty;
	logic       pop = 1'b0;
	verdict_t   verdict;

	int fail_count;
	int owed;
	int items_sent = 0;
	int idle_cycles = 0;
	bit tx_fast = 1'b0;
	bit rx_fast = 1'b0;
	bit hold_pending = 1'b0;

	dotted_version_compare_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.which_string (which_string),
		.is_end       (is_end),
		.char_code    (char_code),
		.empty        (empty),
		.pop          (pop),
		.verdict      (verdict)
	);

	dvc_checker CHK (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.which_string (which_string),
		.is_end       (is_end),
		.char_code    (char_code),
		.empty        (empty),
		.pop          (pop),
		.verdict      (verdict),
		.fail_count   (fail_count),
		.owed         (owed)
	);

	// clock
	always #10 clk = ~clk;

	// watchdog on cycles with no request moving on either side
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// one request after a random gap, held until accepted
	task automatic send_item(input logic s, input logic e, input logic [7:0] c);
		int gap;
		gap = tx_fast ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push         <= 1'b1;
		which_string <= s;
		is_end       <= e;
		char_code    <= c;
		do @(posedge clk); while (full);
		items_sent++;
	endtask

	// whole string followed by its end request
	task automatic send_string(input logic s, input char_q_t chars);
		int i;
		for (i = 0; i < chars.size(); i++) begin
			send_item(s, 1'b0, chars[i]);
		end
		send_item(s, 1'b1, 8'($urandom_range(0, 255)));
	endtask

	// current and remote strings mixed request by request
	task automatic send_interleaved(input char_q_t cur_chars, input char_q_t rem_chars);
		int i;
		int j;
		bit take_cur;
		i = 0;
		j = 0;
		while (i <= cur_chars.size() || j <= rem_chars.size()) begin
			take_cur = (i <= cur_chars.size()) &&
				(j > rem_chars.size() || $urandom_range(0, 1) == 1);
			if (take_cur) begin
				if (i == cur_chars.size()) begin
					send_item(STR_CURRENT, 1'b1, 8'h00);
				end else begin
					send_item(STR_CURRENT, 1'b0, cur_chars[i]);
				end
				i++;
			end else begin
				if (j == rem_chars.size()) begin
					send_item(STR_REMOTE, 1'b1, 8'hFF);
				end else begin
					send_item(STR_REMOTE, 1'b0, rem_chars[j]);
				end
				j++;
			end
		end
	endtask

	function automatic char_q_t to_chars(input string txt);
		char_q_t q;
		int i;
		for (i = 0; i < txt.len(); i++) begin
			q.push_back(txt[i]);
		end
		return q;
	endfunction

	// mostly small parts, now and then the top of the range or past it
	function automatic longint unsigned pick_part();
		case ($urandom_range(0, 39))
			0: return 64'd4294967295;
			1: return 64'd4294967290 + $urandom_range(0, 9);
			2: return 64'd4294967296 + $urandom_range(0, 100000);
			3, 4, 5, 6, 7, 8, 9, 10: return $urandom_range(0, 999);
			default: return $urandom_range(0, 9);
		endcase
	endfunction

	function automatic part_q_t pick_version();
		part_q_t p;
		int n;
		int i;
		if ($urandom_range(0, 19) == 0) begin
			n = $urandom_range(PARTS + 1, PARTS + 3);
		end else begin
			n = $urandom_range(1, PARTS);
		end
		for (i = 0; i < n; i++) begin
			p.push_back(pick_part());
		end
		return p;
	endfunction

	// a remote version close to the current one so the compare runs deep
	function automatic part_q_t near_version(input part_q_t base);
		part_q_t p;
		int k;
		p = base;
		if (p.size() == 0) begin
			return pick_version();
		end
		k = $urandom_range(0, p.size() - 1);
		case (tweak_t'($urandom_range(0, 5)))
			TW_SAME: ;
			TW_BUMP: p[k]++;
			TW_DROP: if (p[k] > 0) p[k]--;
			TW_TRIM: void'(p.pop_back());
			TW_GROW: p.push_back(pick_part());
			TW_FRESH: p = pick_version();
		endcase
		return p;
	endfunction

	// decimal text of the parts, optionally broken
	function automatic char_q_t render(input part_q_t p, input bit spoil);
		char_q_t q;
		string txt;
		int i;
		int k;
		for (i = 0; i < p.size(); i++) begin
			if (i > 0) begin
				q.push_back(CH_DOT);
			end
			// leading zero keeps the value
			if ($urandom_range(0, 19) == 0) begin
				q.push_back(CH_ZERO);
			end
			txt = $sformatf("%0d", p[i]);
			for (k = 0; k < txt.len(); k++) begin
				q.push_back(txt[k]);
			end
		end
		if (spoil) begin
			case (spoil_t'($urandom_range(0, 4)))
				SP_LEAD_DOT: q.push_front(CH_DOT);
				SP_TRAIL_DOT: q.push_back(CH_DOT);
				SP_STRAY_BYTE: q.insert($urandom_range(0, q.size()), 8'($urandom_range(0, 255)));
				SP_EXTRA_DOT: q.insert($urandom_range(0, q.size()), CH_DOT);
				SP_EMPTY: q.delete();
			endcase
		end
		return q;
	endfunction

	// result side: random pop gaps, one long hold when asked
	initial begin : result_side
		int gap;
		wait (arst_n);
		forever begin
			if (hold_pending) begin
				hold_pending = 1'b0;
				gap = HOLD_CYCLES;
			end else begin
				gap = rx_fast ? 0 : $urandom_range(0, 6);
			end
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			if ($urandom_range(0, 23) == 0) begin
				rx_fast = ~rx_fast;
			end
		end
	end

	// request side
	initial begin : stimulus
		part_q_t cur;
		part_q_t nxt;
		char_q_t none;
		bit      pressed;
		int      i;
		pressed = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// hand-picked cases
		send_string(STR_REMOTE, none);                 // no current string yet
		send_string(STR_CURRENT, to_chars("9.0"));
		send_string(STR_REMOTE, to_chars("10"));       // newer
		send_string(STR_REMOTE, to_chars("9"));        // equal after zero fill
		send_string(STR_REMOTE, to_chars(".9"));       // leading dot
		send_item(STR_REMOTE, 1'b0, 8'hFF);            // non-digit byte
		send_item(STR_REMOTE, 1'b1, 8'h00);
		send_string(STR_REMOTE, none);                 // empty remote
		send_item(STR_CURRENT, 1'b0, 8'h00);           // malformed current
		send_item(STR_CURRENT, 1'b1, 8'hFF);
		send_string(STR_REMOTE, to_chars("1"));        // verdict with no valid current

		// random versions
		cur = pick_version();
		send_string(STR_CURRENT, render(cur, 1'b0));
		while (items_sent < ITEM_TARGET) begin
			if (!pressed && items_sent > PRESSURE_AT) begin
				// long result stall while requests keep coming back to back
				pressed      = 1'b1;
				hold_pending = 1'b1;
				tx_fast      = 1'b1;
				for (i = 0; i < 12; i++) begin
					send_string(STR_REMOTE, render(near_version(cur), 1'b0));
				end
			end
			if ($urandom_range(0, 15) == 0) begin
				tx_fast = ~tx_fast;
			end
			case ($urandom_range(0, 19))
				0, 1, 2: begin
					cur = pick_version();
					send_string(STR_CURRENT, render(cur, $urandom_range(0, 5) == 0));
				end
				3: begin
					nxt = pick_version();
					send_interleaved(render(nxt, $urandom_range(0, 5) == 0),
						render(near_version(cur), $urandom_range(0, 5) == 0));
					cur = nxt;
				end
				4: send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					8'($urandom_range(0, 255)));
				default: send_string(STR_REMOTE,
					render(near_version(cur), $urandom_range(0, 7) == 0));
			endcase
		end
		push <= 1'b0;

		// drain
		while (owed != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/dvc_pkg.sv
rtl/dvc_queue.sv
rtl/dvc_front.sv
rtl/dvc_back.sv
rtl/dotted_version_compare_top.sv
sim/dvc_tb_pkg.sv
sim/dvc_checker.sv
sim/testbench.sv
